// ===== src/xtea_pkg.sv =====
`default_nettype none

package xtea_pkg;

  localparam int unsigned HALF_ROUNDS_DEF = 64;
  localparam logic [31:0] XTEA_DELTA      = 32'h9E37_79B9;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned KEY_CNT  = 4;
  localparam int unsigned KEY_IDX_W = $clog2(KEY_CNT);
  localparam int unsigned PADDR_W  = KEY_IDX_W + 2;

  typedef logic [KEY_CNT-1:0][WORD_W-1:0] key_t;

  // One block in flight: the two halves, the running sum and the direction.
  typedef struct packed {
    logic              mode;
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] sum;
  } xtea_data_t;

  function automatic logic [WORD_W-1:0] xtea_mix(
    input logic [WORD_W-1:0] v,
    input logic [WORD_W-1:0] sum,
    input logic [WORD_W-1:0] key
  );
    logic [WORD_W-1:0] t;
    t = ((v << 4) ^ (v >> 5)) + v;
    return t ^ (sum + key);
  endfunction

endpackage

`default_nettype wire

// ===== src/xtea_cell.sv =====
`default_nettype none

module xtea_cell #(
  parameter bit IS_ODD = 1'b0
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire xtea_pkg::key_t      key_i,
  input  wire logic                up_valid_i,
  input  wire xtea_pkg::xtea_data_t up_data_i,
  output logic                     up_stall_o,
  output logic                     dn_valid_o,
  output xtea_pkg::xtea_data_t     dn_data_o,
  input  wire logic                dn_stall_i
);
  import xtea_pkg::*;

  logic       valid_q, valid_d;
  xtea_data_t data_q, data_d;
  logic       advance;
  logic [WORD_W-1:0] key_lo, key_hi;

  // Take a new request whenever this cell is empty or its contents move on.
  assign advance    = !valid_q || !dn_stall_i;
  assign up_stall_o = !advance;
  assign valid_d    = advance ? up_valid_i : valid_q;

  assign key_lo = key_i[up_data_i.sum[KEY_IDX_W-1:0]];
  assign key_hi = key_i[up_data_i.sum[11 +: KEY_IDX_W]];

  always_comb begin
    data_d = up_data_i;
    if (IS_ODD) begin
      if (!up_data_i.mode) begin
        data_d.v1 = up_data_i.v1 + xtea_mix(up_data_i.v0, up_data_i.sum, key_hi);
      end else begin
        data_d.v0 = up_data_i.v0 - xtea_mix(up_data_i.v1, up_data_i.sum, key_lo);
      end
    end else begin
      if (!up_data_i.mode) begin
        data_d.v0  = up_data_i.v0 + xtea_mix(up_data_i.v1, up_data_i.sum, key_lo);
        data_d.sum = up_data_i.sum + XTEA_DELTA;
      end else begin
        data_d.v1  = up_data_i.v1 - xtea_mix(up_data_i.v0, up_data_i.sum, key_hi);
        data_d.sum = up_data_i.sum - XTEA_DELTA;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && up_valid_i) begin
      data_q <= data_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule

`default_nettype wire

// ===== src/xtea_block_cipher_top.sv =====
`default_nettype none

// Channel   Handshake                 Payload
// in        in_valid_i / in_stall_o   mode_i, block_left_i, block_right_i
// out       out_valid_o / out_stall_i out_left_o, out_right_o
// cfg       APB write/read            key words at byte addresses 0, 4, 8, 12
//
// One block enters per cycle while the input is not stalled; each of HALF_ROUNDS cells
// does one half-round and registers it, so a block passes every cell in turn.
// Each cell moves on when it is empty or its neighbor takes its block, so
// bubbles close up under a stall and the input keeps taking requests until
// every cell is full. Reset clears the cell valid bits and the key words.
module xtea_block_cipher_top #(
  parameter int unsigned HALF_ROUNDS = xtea_pkg::HALF_ROUNDS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [xtea_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [xtea_pkg::WORD_W-1:0]   pwdata,
  output logic      [xtea_pkg::WORD_W-1:0]   prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          mode_i,
  input  wire logic [xtea_pkg::WORD_W-1:0]   block_left_i,
  input  wire logic [xtea_pkg::WORD_W-1:0]   block_right_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [xtea_pkg::WORD_W-1:0]   out_left_o,
  output logic      [xtea_pkg::WORD_W-1:0]   out_right_o
);
  import xtea_pkg::*;

  localparam logic [WORD_W-1:0] DEC_SUM = WORD_W'(XTEA_DELTA * WORD_W'(HALF_ROUNDS / 2));

  key_t       key_q;
  logic [KEY_IDX_W-1:0] reg_idx;
  logic [HALF_ROUNDS:0] valid;
  logic [HALF_ROUNDS:0] stall;
  xtea_data_t data [HALF_ROUNDS+1];

  // Configuration port
  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = key_q[reg_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (psel && penable && pwrite) begin
      key_q[reg_idx] <= pwdata;
    end
  end

  // Chain input
  assign valid[0]      = in_valid_i;
  assign data[0].mode  = mode_i;
  assign data[0].v0    = block_left_i;
  assign data[0].v1    = block_right_i;
  assign data[0].sum   = mode_i ? DEC_SUM : '0;
  assign in_stall_o    = stall[0];
  assign stall[HALF_ROUNDS] = out_stall_i;

  for (genvar i = 0; i < HALF_ROUNDS; i++) begin : g_cell
    xtea_cell #(
      .IS_ODD (1'(i % 2))
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .key_i      (key_q),
      .up_valid_i (valid[i]),
      .up_data_i  (data[i]),
      .up_stall_o (stall[i]),
      .dn_valid_o (valid[i+1]),
      .dn_data_o  (data[i+1]),
      .dn_stall_i (stall[i+1])
    );
  end

  assign out_valid_o = valid[HALF_ROUNDS];
  assign out_left_o  = data[HALF_ROUNDS].v0;
  assign out_right_o = data[HALF_ROUNDS].v1;

  // The input holds off only when every cell is full and the output is stalled.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&valid[HALF_ROUNDS:1]) && out_stall_i))
    else $error("input stalled with a free cell");

  // A result only leaves when it is taken.
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

  // An empty output stage never holds off the last cell.
  a_last_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !stall[HALF_ROUNDS-1])
    else $error("last cell stalled behind an empty output");

endmodule

`default_nettype wire
